[hdl/ffha_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the first-fit heap allocator.
// No dependencies; ffha_datapath, ffha_ctrl and the top level import this package.
package ffha_pkg;

  localparam int HEAP_BYTES_DEF = 65536;

  // Header word encodings
  localparam logic [31:0] LINK_NONE  = 32'hFFFF_FFFF;
  localparam logic [31:0] HEAD_NODE  = 32'hFFFF_FFFE;
  localparam logic [31:0] ALLOC_MARK = 32'h8000_0000;
  localparam logic [31:0] HDR_BYTES  = 32'd8;
  localparam logic [31:0] ALIGN_MASK = 32'd7;
  localparam logic [31:0] SPLIT_MIN  = 32'd16;

  typedef enum logic [1:0] {
    ST_ALLOC_OK   = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_FREED      = 2'd2,
    ST_IGNORED    = 2'd3
  } rsp_status_t;

  // Datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_ACCEPT,
    OP_RD_BSZ, OP_RD_BLK, OP_AWALK, OP_UNLINK, OP_SPLIT1, OP_SPLIT2,
    OP_TAKE1, OP_TAKE2,
    OP_RD_FSZ, OP_RD_FLK, OP_FREL,
    OP_PB_INIT, OP_PB_STEP, OP_PB_LAT, OP_PB_RSA, OP_PB_MRG,
    OP_PB_RA1, OP_PB_RA2, OP_PB_J1, OP_PB_J2, OP_PB_NX, OP_PB_LINK,
    OP_DONE_OK, OP_DONE_FAIL, OP_DONE_FREED, OP_DONE_IGN
  } dp_op_t;

  // Status returned by the datapath
  typedef struct packed {
    logic clr_done;
    logic out_free;
    logic opc_free;
    logic need_bad;
    logic ptr_bad;
    logic a_adv;
    logic a_limit;
    logic blk_end;
    logic split;
    logic f_ok;
    logic pb_adv;
    logic at_head;
    logic touch_mid;
  } dp_flags_t;

endpackage

[hdl/ffha_req_if.sv]
`timescale 1ns / 1ps
// Request channel interface: valid/ready plus the request payload.
// Stand-alone; no package needed.
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_bytes;
  logic [15:0] release_offset;

  modport source(output valid, opcode, request_bytes, release_offset, input ready);
  modport sink(input valid, opcode, request_bytes, release_offset, output ready);
endinterface

[hdl/ffha_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel interface: valid/ready plus the result payload.
// Stand-alone; no package needed.
interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] block_offset;
  logic [16:0] free_bytes;
  logic [16:0] min_free_bytes;

  modport source(output valid, status, block_offset, free_bytes, min_free_bytes,
                 input ready);
  modport sink(input valid, status, block_offset, free_bytes, min_free_bytes,
               output ready);
endinterface

[hdl/ffha_datapath.sv]
`timescale 1ns / 1ps
// Allocator datapath: heap word memory, walk registers, counters, result register.
// Depends on ffha_pkg; driven by ffha_ctrl through dp_op_t commands.
module ffha_datapath import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_op_t      op,
  input  logic        in_opcode,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_release_offset,
  input  logic        out_ready,
  output dp_flags_t   flags,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_block_offset,
  output logic [16:0] out_free_bytes,
  output logic [16:0] out_min_free_bytes
);

  localparam int          WORD_COUNT   = HEAP_BYTES / 4;
  localparam int          AW           = $clog2(WORD_COUNT);
  localparam logic [31:0] WORD_COUNT_W = 32'(WORD_COUNT);
  localparam logic [31:0] END_OFF      = 32'(HEAP_BYTES - 8) & ~ALIGN_MASK;
  localparam logic [31:0] END_IDX      = END_OFF >> 2;
  localparam int          WALK_LIMIT   = HEAP_BYTES / 8 + 2;
  localparam int          SW           = $clog2(WALK_LIMIT + 1);

  // Heap word store
  logic [31:0] mem [WORD_COUNT];

  logic          opc_r, opc_nxt;
  logic [15:0]   rel_r, rel_nxt;
  logic [31:0]   need_r, need_nxt, blk_r, blk_nxt, prev_r, prev_nxt;
  logic [31:0]   lnk_r, lnk_nxt, sz_r, sz_nxt, at_r, at_nxt, lat_r, lat_nxt;
  logic [31:0]   pb_r, pb_nxt, pbsz_r, pbsz_nxt, sa_r, sa_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [31:0]   head_r, head_nxt, free_r, free_nxt, low_r, low_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_status_t   out_status_r, out_status_nxt;
  logic [15:0]   out_off_r, out_off_nxt;
  logic [16:0]   out_free_r, out_free_nxt, out_min_r, out_min_nxt;
  logic [31:0]   rdata_r;
  logic          rd_ok_r;

  logic          rd_req, wr_req, rd_w, wr_w, rd_ok, wr_ok;
  logic [31:0]   rd_off, wr_off, wdata, rd_idx, wr_idx, rdval;
  logic [31:0]   fnew, fsz, msum;

  function automatic logic [31:0] widx(input logic [31:0] off, input logic w);
    widx = {2'b00, off[31:2]} + {31'd0, w};
  endfunction

  assign rdval = rd_ok_r ? rdata_r : 32'd0;
  assign fnew  = free_r - sz_r;
  assign fsz   = sz_r & ~ALLOC_MARK;
  assign msum  = at_r + rdval;

  // Status toward the controller
  always_comb begin
    flags.clr_done  = (clr_idx_r == AW'(WORD_COUNT - 1));
    flags.out_free  = !out_valid_r || out_ready;
    flags.opc_free  = opc_r;
    flags.need_bad  = (need_r == 32'd0) || (need_r > free_r);
    flags.ptr_bad   = !((rel_r >= 16'd8) && (rel_r[2:0] == 3'd0) &&
                        (({16'd0, rel_r} - HDR_BYTES) <= END_OFF));
    flags.a_adv     = (sz_r < need_r) && (rdval != LINK_NONE);
    flags.a_limit   = (steps_r >= SW'(WALK_LIMIT));
    flags.blk_end   = (blk_r == END_OFF);
    flags.split     = ((sz_r - need_r) > SPLIT_MIN);
    flags.f_ok      = sz_r[31] && (rdval == LINK_NONE);
    flags.pb_adv    = (lat_r < pb_r) && (steps_r < SW'(WALK_LIMIT));
    flags.at_head   = (at_r == HEAD_NODE);
    flags.touch_mid = ((pb_r + pbsz_r) == lat_r) && (lat_r != END_OFF);
  end

  // Micro-operation decode
  always_comb begin
    opc_nxt = opc_r;   rel_nxt = rel_r;   need_nxt = need_r; blk_nxt = blk_r;
    prev_nxt = prev_r; lnk_nxt = lnk_r;   sz_nxt = sz_r;     at_nxt = at_r;
    lat_nxt = lat_r;   pb_nxt = pb_r;     pbsz_nxt = pbsz_r; sa_nxt = sa_r;
    steps_nxt = steps_r; head_nxt = head_r; free_nxt = free_r; low_nxt = low_r;
    clr_idx_nxt = clr_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r; out_off_nxt = out_off_r;
    out_free_nxt = out_free_r; out_min_nxt = out_min_r;
    rd_req = 1'b0; rd_off = 32'd0; rd_w = 1'b0;
    wr_req = 1'b0; wr_off = 32'd0; wr_w = 1'b0; wdata = 32'd0;
    case (op)
      OP_CLEAR: begin
        wr_req = 1'b1;
        wr_off = {{(30 - AW){1'b0}}, clr_idx_r, 2'b00};
        if (32'(clr_idx_r) <= 32'd1) wdata = END_OFF;
        else if (32'(clr_idx_r) == END_IDX) wdata = LINK_NONE;
        clr_idx_nxt = clr_idx_r + AW'(1);
      end
      OP_ACCEPT: begin
        opc_nxt   = in_opcode;
        rel_nxt   = in_release_offset;
        need_nxt  = ({16'd0, in_request_bytes} + 32'd15) & ~ALIGN_MASK;
        blk_nxt   = head_r;
        prev_nxt  = HEAD_NODE;
        steps_nxt = '0;
        pb_nxt    = {16'd0, in_release_offset} - HDR_BYTES;
      end
      OP_RD_BSZ: begin
        rd_req = 1'b1; rd_off = blk_r; rd_w = 1'b1;
      end
      OP_RD_BLK: begin
        sz_nxt = rdval;
        rd_req = 1'b1; rd_off = blk_r;
      end
      OP_AWALK: begin
        lnk_nxt = rdval;
        if (flags.a_adv && !flags.a_limit) begin
          prev_nxt  = blk_r;
          blk_nxt   = rdval;
          steps_nxt = steps_r + SW'(1);
        end
      end
      OP_UNLINK: begin
        if (prev_r == HEAD_NODE) head_nxt = lnk_r;
        else begin
          wr_req = 1'b1; wr_off = prev_r; wdata = lnk_r;
        end
      end
      OP_SPLIT1: begin
        wr_req = 1'b1; wr_off = blk_r + need_r; wr_w = 1'b1; wdata = sz_r - need_r;
        pb_nxt   = blk_r + need_r;
        pbsz_nxt = sz_r - need_r;
      end
      OP_SPLIT2: begin
        wr_req = 1'b1; wr_off = blk_r; wr_w = 1'b1; wdata = need_r;
        sz_nxt = need_r;
      end
      OP_TAKE1: begin
        free_nxt = fnew;
        if (fnew < low_r) low_nxt = fnew;
        wr_req = 1'b1; wr_off = blk_r; wr_w = 1'b1; wdata = sz_r | ALLOC_MARK;
      end
      OP_TAKE2: begin
        wr_req = 1'b1; wr_off = blk_r; wdata = LINK_NONE;
      end
      OP_RD_FSZ: begin
        rd_req = 1'b1; rd_off = pb_r; rd_w = 1'b1;
      end
      OP_RD_FLK: begin
        sz_nxt = rdval;
        rd_req = 1'b1; rd_off = pb_r;
      end
      OP_FREL: begin
        wr_req = 1'b1; wr_off = pb_r; wr_w = 1'b1; wdata = fsz;
        pbsz_nxt = fsz;
        free_nxt = free_r + fsz;
      end
      OP_PB_INIT: begin
        at_nxt = HEAD_NODE; lat_nxt = head_r; steps_nxt = '0;
      end
      OP_PB_STEP: begin
        if (flags.pb_adv) begin
          at_nxt    = lat_r;
          steps_nxt = steps_r + SW'(1);
          rd_req = 1'b1; rd_off = lat_r;
        end
      end
      OP_PB_LAT: lat_nxt = rdval;
      OP_PB_RSA: begin
        rd_req = 1'b1; rd_off = at_r; rd_w = 1'b1;
      end
      OP_PB_MRG: begin
        // lower neighbor ends where this block starts
        if (msum == pb_r) begin
          wr_req = 1'b1; wr_off = at_r; wr_w = 1'b1; wdata = rdval + pbsz_r;
          pbsz_nxt = rdval + pbsz_r;
          pb_nxt   = at_r;
        end
      end
      OP_PB_RA1: begin
        rd_req = 1'b1; rd_off = lat_r; rd_w = 1'b1;
      end
      OP_PB_RA2: begin
        sa_nxt = rdval;
        rd_req = 1'b1; rd_off = lat_r;
      end
      OP_PB_J1: begin
        wr_req = 1'b1; wr_off = pb_r; wr_w = 1'b1; wdata = pbsz_r + sa_r;
        lnk_nxt = rdval;
      end
      OP_PB_J2: begin
        wr_req = 1'b1; wr_off = pb_r; wdata = lnk_r;
      end
      OP_PB_NX: begin
        wr_req = 1'b1; wr_off = pb_r; wdata = lat_r;
      end
      OP_PB_LINK: begin
        if (at_r != pb_r) begin
          if (at_r == HEAD_NODE) head_nxt = pb_r;
          else begin
            wr_req = 1'b1; wr_off = at_r; wdata = pb_r;
          end
        end
      end
      OP_DONE_OK, OP_DONE_FAIL, OP_DONE_FREED, OP_DONE_IGN: begin
        out_valid_nxt = 1'b1;
        out_off_nxt   = 16'd0;
        out_free_nxt  = free_r[16:0];
        out_min_nxt   = low_r[16:0];
        case (op)
          OP_DONE_OK: begin
            out_status_nxt = ST_ALLOC_OK;
            out_off_nxt    = blk_r[15:0] + 16'd8;
          end
          OP_DONE_FAIL:  out_status_nxt = ST_ALLOC_FAIL;
          OP_DONE_FREED: out_status_nxt = ST_FREED;
          default:       out_status_nxt = ST_IGNORED;
        endcase
      end
      default: ;
    endcase
  end

  // Address range checks: out-of-range reads give zero, writes are dropped
  assign rd_idx = widx(rd_off, rd_w);
  assign wr_idx = widx(wr_off, wr_w);
  assign rd_ok  = ({2'b00, rd_off[31:2]} < WORD_COUNT_W) && (rd_idx < WORD_COUNT_W);
  assign wr_ok  = ({2'b00, wr_off[31:2]} < WORD_COUNT_W) && (wr_idx < WORD_COUNT_W);

  // Memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_req && wr_ok) mem[wr_idx[AW-1:0]] <= wdata;
    if (rd_req) begin
      rd_ok_r <= rd_ok;
      if (rd_ok) rdata_r <= mem[rd_idx[AW-1:0]];
    end
  end

  // Control state and heap bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= 32'd0;
      free_r      <= END_OFF;
      low_r       <= END_OFF;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      low_r       <= low_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    opc_r <= opc_nxt;   rel_r <= rel_nxt;   need_r <= need_nxt; blk_r <= blk_nxt;
    prev_r <= prev_nxt; lnk_r <= lnk_nxt;   sz_r <= sz_nxt;     at_r <= at_nxt;
    lat_r <= lat_nxt;   pb_r <= pb_nxt;     pbsz_r <= pbsz_nxt; sa_r <= sa_nxt;
    steps_r <= steps_nxt;
    out_status_r <= out_status_nxt; out_off_r <= out_off_nxt;
    out_free_r <= out_free_nxt;     out_min_r <= out_min_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_block_offset   = out_off_r;
  assign out_free_bytes     = out_free_r;
  assign out_min_free_bytes = out_min_r;

  // Low-water mark never sits above the live free count
  ap_low_water: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= free_r) else $error("low-water count above free count");

  // A result is only loaded into an empty or draining output register
  ap_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_DONE_OK || op == OP_DONE_FAIL || op == OP_DONE_FREED ||
     op == OP_DONE_IGN) |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending transaction");

endmodule

[hdl/ffha_ctrl.sv]
`timescale 1ns / 1ps
// Allocator controller: sequences the clear pass, first-fit walk, split, free check and reinsert.
// Depends on ffha_pkg; commands ffha_datapath.
module ffha_ctrl import ffha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_flags_t flags,
  output dp_op_t    op
);

  typedef enum logic [30:0] {
    S_CLR    = 31'd1 << 0,  S_IDLE   = 31'd1 << 1,  S_DISP   = 31'd1 << 2,
    S_ARSZ   = 31'd1 << 3,  S_ARLK   = 31'd1 << 4,  S_AWALK  = 31'd1 << 5,
    S_UNLINK = 31'd1 << 6,  S_SPL1   = 31'd1 << 7,  S_SPL2   = 31'd1 << 8,
    S_TAKE1  = 31'd1 << 9,  S_TAKE2  = 31'd1 << 10, S_FRSZ   = 31'd1 << 11,
    S_FRLK   = 31'd1 << 12, S_FTEST  = 31'd1 << 13, S_FREL   = 31'd1 << 14,
    S_PBINI  = 31'd1 << 15, S_PBSTEP = 31'd1 << 16, S_PBLAT  = 31'd1 << 17,
    S_PBRSA  = 31'd1 << 18, S_PBMRG  = 31'd1 << 19, S_PBAFT  = 31'd1 << 20,
    S_PBRA1  = 31'd1 << 21, S_PBRA2  = 31'd1 << 22, S_PBJ1   = 31'd1 << 23,
    S_PBJ2   = 31'd1 << 24, S_PBNX   = 31'd1 << 25, S_PBLNK  = 31'd1 << 26,
    S_OK     = 31'd1 << 27, S_FAIL   = 31'd1 << 28, S_FREED  = 31'd1 << 29,
    S_IGN    = 31'd1 << 30
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    case (state_r)
      S_CLR: begin
        op = OP_CLEAR;
        if (flags.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (flags.opc_free) state_nxt = flags.ptr_bad ? S_IGN : S_FRSZ;
        else state_nxt = flags.need_bad ? S_FAIL : S_ARSZ;
      end
      // first-fit walk, one header per pass
      S_ARSZ: begin op = OP_RD_BSZ; state_nxt = S_ARLK; end
      S_ARLK: begin op = OP_RD_BLK; state_nxt = S_AWALK; end
      S_AWALK: begin
        op = OP_AWALK;
        if (flags.a_adv) state_nxt = flags.a_limit ? S_FAIL : S_ARSZ;
        else state_nxt = flags.blk_end ? S_FAIL : S_UNLINK;
      end
      S_UNLINK: begin
        op = OP_UNLINK;
        state_nxt = flags.split ? S_SPL1 : S_TAKE1;
      end
      S_SPL1:  begin op = OP_SPLIT1; state_nxt = S_SPL2; end
      S_SPL2:  begin op = OP_SPLIT2; state_nxt = S_PBINI; end
      S_TAKE1: begin op = OP_TAKE1;  state_nxt = S_TAKE2; end
      S_TAKE2: begin op = OP_TAKE2;  state_nxt = S_OK; end
      // free: header check
      S_FRSZ:  begin op = OP_RD_FSZ; state_nxt = S_FRLK; end
      S_FRLK:  begin op = OP_RD_FLK; state_nxt = S_FTEST; end
      S_FTEST: state_nxt = flags.f_ok ? S_FREL : S_IGN;
      S_FREL:  begin op = OP_FREL; state_nxt = S_PBINI; end
      // address-ordered reinsert with coalescing
      S_PBINI: begin op = OP_PB_INIT; state_nxt = S_PBSTEP; end
      S_PBSTEP: begin
        op = OP_PB_STEP;
        if (flags.pb_adv) state_nxt = S_PBLAT;
        else state_nxt = flags.at_head ? S_PBAFT : S_PBRSA;
      end
      S_PBLAT: begin op = OP_PB_LAT; state_nxt = S_PBSTEP; end
      S_PBRSA: begin op = OP_PB_RSA; state_nxt = S_PBMRG; end
      S_PBMRG: begin op = OP_PB_MRG; state_nxt = S_PBAFT; end
      S_PBAFT: state_nxt = flags.touch_mid ? S_PBRA1 : S_PBNX;
      S_PBRA1: begin op = OP_PB_RA1; state_nxt = S_PBRA2; end
      S_PBRA2: begin op = OP_PB_RA2; state_nxt = S_PBJ1; end
      S_PBJ1:  begin op = OP_PB_J1;  state_nxt = S_PBJ2; end
      S_PBJ2:  begin op = OP_PB_J2;  state_nxt = S_PBLNK; end
      S_PBNX:  begin op = OP_PB_NX;  state_nxt = S_PBLNK; end
      S_PBLNK: begin
        op = OP_PB_LINK;
        state_nxt = flags.opc_free ? S_FREED : S_TAKE1;
      end
      // results wait for a free output register
      S_OK: if (flags.out_free) begin op = OP_DONE_OK; state_nxt = S_IDLE; end
      S_FAIL: if (flags.out_free) begin op = OP_DONE_FAIL; state_nxt = S_IDLE; end
      S_FREED: if (flags.out_free) begin op = OP_DONE_FREED; state_nxt = S_IDLE; end
      S_IGN: if (flags.out_free) begin op = OP_DONE_IGN; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  ap_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted transaction not dispatched");

  ap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && !flags.clr_done) |=> (state_r == S_CLR && !in_ready))
    else $error("clear pass left early");

  ap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_DONE_OK || op == OP_DONE_FAIL || op == OP_DONE_FREED ||
     op == OP_DONE_IGN) |=> (state_r == S_IDLE))
    else $error("no return to idle after result");

endmodule

[hdl/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// First-fit heap allocator with address-ordered free list and coalescing.
// Top level; depends on ffha_pkg, ffha_req_if, ffha_rsp_if, ffha_ctrl, ffha_datapath.
//
// Usage:
//   in_chan carries one request per transaction (opcode 0 allocate with
//   request_bytes, opcode 1 free with release_offset). out_chan returns one
//   result per request: status, user offset, free bytes and low-water mark.
//   After reset the block sweeps the heap memory once, one word per cycle,
//   with in_chan.ready low; it then holds one free block and the end marker.
//   An allocate walks the free list one header per step over the heap
//   memory's single read port; when the block is split, the remainder is
//   reinserted by a walk over the list entries below it. A free walks the
//   list entries below the released block before it is linked in. A
//   rejected allocate or an ignored free does no list walk.
//   One request is processed at a time; in_chan.ready is high only when idle.
//   The result sits in an output register; a new request is accepted while
//   it waits, but that request's result stalls until out_chan takes the old one.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  ffha_req_if.sink   in_chan,
  ffha_rsp_if.source out_chan
);

  dp_op_t    op;
  dp_flags_t flags;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .flags    (flags),
    .op       (op)
  );

  ffha_datapath #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .in_opcode          (in_chan.opcode),
    .in_request_bytes   (in_chan.request_bytes),
    .in_release_offset  (in_chan.release_offset),
    .out_ready          (out_chan.ready),
    .flags              (flags),
    .out_valid          (out_chan.valid),
    .out_status         (out_chan.status),
    .out_block_offset   (out_chan.block_offset),
    .out_free_bytes     (out_chan.free_bytes),
    .out_min_free_bytes (out_chan.min_free_bytes)
  );

endmodule
